// ===== rtl/ste_pkg.sv =====
package ste_pkg;

	// Grid geometry. The side is a power of two so a cell index is {row, col}.
	localparam int GRID_SIDE  = 256;
	localparam int SIDE_W     = $clog2(GRID_SIDE);
	localparam int CELL_W     = 2 * SIDE_W;
	localparam int CNT_W      = CELL_W + 1;
	localparam int CELL_TOTAL = GRID_SIDE * GRID_SIDE;

	// Fixed field widths of the stream words.
	localparam int COORD_W   = 16;
	localparam int GRAIN_W   = 32;
	localparam int REPORT_W  = 17;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 72;
	localparam logic [GRAIN_W-1:0] UNSTABLE_LEVEL = 32'd4;

	// Operation codes of the input word.
	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_ROUND = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_ORIGIN_X = 1'b0,
		REG_ORIGIN_Y = 1'b1
	} reg_idx_t;

	// Controller states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_CELL_RD,
		ST_ADD_WB,
		ST_READ_CAP,
		ST_ROUND,
		ST_POP,
		ST_TOP_RD,
		ST_SELF_WB,
		ST_NB_RD,
		ST_NB_WB,
		ST_DONE
	} state_t;

	// One datapath command per cycle.
	typedef enum logic [3:0] {
		DP_NOP,
		DP_CLEAR,
		DP_LATCH,
		DP_CELL_RD,
		DP_ADD_WB,
		DP_READ_CAP,
		DP_ROUND_START,
		DP_POP,
		DP_TOP_RD,
		DP_SELF_WB,
		DP_NB_RD,
		DP_NB_WB,
		DP_RESULT
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		op_t  op;
		logic count_zero;
		logic nb_inside;
		logic nb_last;
		logic round_last;
		logic out_free;
	} dp_status_t;

	// Saturating add of a grain count.
	function automatic logic [GRAIN_W-1:0] sat_add(input logic [GRAIN_W-1:0] a,
		input logic [GRAIN_W-1:0] b);
		logic [GRAIN_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[GRAIN_W] ? {GRAIN_W{1'b1}} : s[GRAIN_W-1:0];
	endfunction

endpackage

// ===== rtl/ste_ctrl.sv =====
module ste_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  ste_pkg::dp_status_t st,
	output ste_pkg::dp_cmd_t    cmd
);
	import ste_pkg::*;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath command.
	always_comb begin
		state_d  = state_q;
		cmd      = DP_NOP;
		s_tready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd = DP_CLEAR;
				if (st.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd     = DP_LATCH;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (st.op)
					OP_ADD, OP_READ: state_d = ST_CELL_RD;
					OP_ROUND:        state_d = ST_ROUND;
					default:         state_d = ST_DONE;
				endcase
			end
			ST_CELL_RD: begin
				cmd     = DP_CELL_RD;
				state_d = (st.op == OP_ADD) ? ST_ADD_WB : ST_READ_CAP;
			end
			ST_ADD_WB: begin
				cmd     = DP_ADD_WB;
				state_d = ST_DONE;
			end
			ST_READ_CAP: begin
				cmd     = DP_READ_CAP;
				state_d = ST_DONE;
			end
			ST_ROUND: begin
				cmd     = DP_ROUND_START;
				state_d = st.count_zero ? ST_DONE : ST_POP;
			end
			ST_POP: begin
				cmd     = DP_POP;
				state_d = ST_TOP_RD;
			end
			ST_TOP_RD: begin
				cmd     = DP_TOP_RD;
				state_d = ST_SELF_WB;
			end
			ST_SELF_WB: begin
				cmd     = DP_SELF_WB;
				state_d = ST_NB_RD;
			end
			ST_NB_RD: begin
				cmd = DP_NB_RD;
				if (st.nb_inside) begin
					state_d = ST_NB_WB;
				end else if (st.nb_last) begin
					state_d = st.round_last ? ST_DONE : ST_POP;
				end
			end
			ST_NB_WB: begin
				cmd = DP_NB_WB;
				if (st.nb_last) begin
					state_d = st.round_last ? ST_DONE : ST_POP;
				end else begin
					state_d = ST_NB_RD;
				end
			end
			ST_DONE: begin
				if (st.out_free) begin
					cmd     = DP_RESULT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

endmodule

// ===== rtl/ste_dp.sv =====
module ste_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ste_pkg::dp_cmd_t                    cmd,
	output ste_pkg::dp_status_t                 st,
	input  logic                                cfg_valid,
	input  logic                                cfg_index,
	input  logic [ste_pkg::COORD_W-1:0]         cfg_data,
	input  logic [ste_pkg::IN_DATA_W-1:0]       s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [ste_pkg::OUT_DATA_W-1:0]      m_tdata
);
	import ste_pkg::*;

	// Memories: grain counts and the ring of unstable cells.
	logic [GRAIN_W-1:0] gmem [CELL_TOTAL];
	logic [CELL_W-1:0]  qmem [CELL_TOTAL];
	logic [GRAIN_W-1:0] g_rd_q;
	logic [CELL_W-1:0]  q_rd_q;

	logic [COORD_W-1:0] origin_x_q, origin_y_q;
	op_t                op_q;
	logic [CELL_W-1:0]  cell_q, nb_cell_q, clr_q, head_q, tail_q;
	logic               on_grid_q, lost_q, out_valid_q;
	logic [GRAIN_W-1:0] grains_q, value_q;
	logic [CNT_W-1:0]   count_q, round_left_q, topples_q;
	logic [1:0]         nb_q;
	logic [OUT_DATA_W-1:0] out_q;

	// Locate the input cell on the grid.
	logic [COORD_W-1:0] col_in, row_in;
	assign col_in = s_tdata[17:2] - origin_x_q;
	assign row_in = s_tdata[33:18] - origin_y_q;

	// Neighbor address of the toppled cell, in the order x+1, y+1, x-1, y-1.
	logic [SIDE_W-1:0] col_c, row_c, nb_col, nb_row;
	logic              nb_inside;
	assign col_c = cell_q[SIDE_W-1:0];
	assign row_c = cell_q[CELL_W-1:SIDE_W];
	always_comb begin
		nb_col    = col_c;
		nb_row    = row_c;
		nb_inside = 1'b1;
		case (nb_q)
			2'd0: begin
				nb_col    = col_c + 1'b1;
				nb_inside = (col_c != SIDE_W'(GRID_SIDE - 1));
			end
			2'd1: begin
				nb_row    = row_c + 1'b1;
				nb_inside = (row_c != SIDE_W'(GRID_SIDE - 1));
			end
			2'd2: begin
				nb_col    = col_c - 1'b1;
				nb_inside = (col_c != '0);
			end
			default: begin
				nb_row    = row_c - 1'b1;
				nb_inside = (row_c != '0);
			end
		endcase
	end

	// Grain memory port selection and read-modify-write values.
	logic               g_we, q_push, crossed;
	logic [CELL_W-1:0]  g_wa, g_ra, q_wd;
	logic [GRAIN_W-1:0] g_wd, added, topped;
	always_comb begin
		g_we   = 1'b0;
		g_wa   = cell_q;
		g_wd   = '0;
		g_ra   = cell_q;
		q_push = 1'b0;
		q_wd   = cell_q;
		added  = sat_add(g_rd_q, (cmd == DP_NB_WB) ? GRAIN_W'(1) : grains_q);
		topped = (g_rd_q >= UNSTABLE_LEVEL) ? g_rd_q - UNSTABLE_LEVEL : '0;
		crossed = (g_rd_q < UNSTABLE_LEVEL) && (added >= UNSTABLE_LEVEL);
		case (cmd)
			DP_CLEAR: begin
				g_we = 1'b1;
				g_wa = clr_q;
			end
			DP_ADD_WB: begin
				g_we   = on_grid_q;
				g_wd   = added;
				q_push = on_grid_q && crossed;
			end
			DP_TOP_RD: g_ra = q_rd_q;
			DP_SELF_WB: begin
				g_we   = 1'b1;
				g_wd   = topped;
				q_push = (topped >= UNSTABLE_LEVEL);
			end
			DP_NB_RD: g_ra = {nb_row, nb_col};
			DP_NB_WB: begin
				g_we   = 1'b1;
				g_wa   = nb_cell_q;
				g_wd   = added;
				q_push = crossed;
				q_wd   = nb_cell_q;
			end
			default: g_we = 1'b0;
		endcase
	end

	// Push only into a queue that is not full.
	logic push_ok, pop_ok, nb_step;
	assign push_ok = q_push && (count_q != CNT_W'(CELL_TOTAL));
	assign pop_ok  = (cmd == DP_POP);
	assign nb_step = ((cmd == DP_NB_RD) && !nb_inside) || (cmd == DP_NB_WB);

	always_ff @(posedge clk) begin
		if (g_we) gmem[g_wa] <= g_wd;
		g_rd_q <= gmem[g_ra];
		if (push_ok) qmem[tail_q] <= q_wd;
		q_rd_q <= qmem[head_q];
	end

	// Control registers: queue pointers, flag, configuration, output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			clr_q        <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			lost_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			round_left_q <= '0;
			nb_q         <= '0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_ORIGIN_X) origin_x_q <= cfg_data;
				else                           origin_y_q <= cfg_data;
			end
			if (cmd == DP_CLEAR) clr_q <= clr_q + 1'b1;
			if (push_ok) tail_q <= tail_q + 1'b1;
			if (pop_ok)  head_q <= head_q + 1'b1;
			if (push_ok && !pop_ok)      count_q <= count_q + 1'b1;
			else if (pop_ok && !push_ok) count_q <= count_q - 1'b1;
			if (cmd == DP_ADD_WB && !on_grid_q && grains_q != '0) lost_q <= 1'b1;
			if (cmd == DP_NB_RD && !nb_inside) lost_q <= 1'b1;
			if (cmd == DP_ROUND_START) round_left_q <= count_q;
			if (cmd == DP_TOP_RD) nb_q <= '0;
			if (nb_step) begin
				nb_q <= nb_q + 1'b1;
				if (nb_q == 2'd3) round_left_q <= round_left_q - 1'b1;
			end
			if (cmd == DP_RESULT) out_valid_q <= 1'b1;
			else if (m_tready)    out_valid_q <= 1'b0;
		end
	end

	// Payload registers of the item at work.
	always_ff @(posedge clk) begin
		if (cmd == DP_LATCH) begin
			op_q      <= op_t'(s_tdata[1:0]);
			grains_q  <= s_tdata[65:34];
			cell_q    <= {row_in[SIDE_W-1:0], col_in[SIDE_W-1:0]};
			on_grid_q <= (col_in < COORD_W'(GRID_SIDE)) && (row_in < COORD_W'(GRID_SIDE));
			value_q   <= '0;
			topples_q <= '0;
		end
		if (cmd == DP_READ_CAP) value_q <= on_grid_q ? g_rd_q : '0;
		if (cmd == DP_ROUND_START) topples_q <= count_q;
		if (cmd == DP_TOP_RD) cell_q <= q_rd_q;
		if (cmd == DP_NB_RD) nb_cell_q <= {nb_row, nb_col};
		if (cmd == DP_RESULT) begin
			out_q <= {5'd0, lost_q, REPORT_W'(topples_q), REPORT_W'(count_q), value_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	assign st.clr_last   = (clr_q == CELL_W'(CELL_TOTAL - 1));
	assign st.op         = op_q;
	assign st.count_zero = (count_q == '0);
	assign st.nb_inside  = nb_inside;
	assign st.nb_last    = (nb_q == 2'd3);
	assign st.round_last = (round_left_q == CNT_W'(1));
	assign st.out_free   = !out_valid_q || m_tready;

endmodule

// ===== rtl/sandpile_topple_engine_unit.sv =====
// Abelian sandpile engine on a 256 by 256 grid. After reset the block zeroes
// every cell of the grain memory and takes no word meanwhile. An add or a read
// reads its cell through the registered read of the grain memory and then writes
// back the sum or captures the value; a round topples each cell queued when it
// began, each topple a queue read and up to five read-modify-writes on the single
// grain memory (one less for each neighbor past a grid edge). One item is worked
// at a time; the result word waits in an output register.
module sandpile_topple_engine_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [ste_pkg::COORD_W-1:0]       cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// operation[1:0], x[17:2], y[33:18], grain_count[65:34], zero fill
	input  logic [ste_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// cell_grains[31:0], pending[48:32], topples[65:49], off_grid[66], zero fill
	output logic [ste_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import ste_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	assign cfg_ready = 1'b1;

	ste_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	ste_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ===== rtl/ste_chk.sv =====
module ste_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [ste_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import ste_pkg::*;

	// Remembers whether a delivered word already showed the off-grid flag.
	logic seen_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (m_tvalid && m_tready && m_tdata[66]) begin
			seen_q <= 1'b1;
		end
	end

	// A stalled result word stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	// The off-grid flag never clears once reported.
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q && m_tvalid |-> m_tdata[66])
		else $error("off-grid flag cleared");

	// One item at a time: input closes right after an accepted word.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word accepted while busy");

	// Padding bits of the result word stay zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[71:67] == 5'd0)
		else $error("result padding not zero");

endmodule

bind sandpile_topple_engine_unit ste_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
